[sv/bcmio_pkg.sv]
// ----------------------------------------------------------------------------
// Bus cycle decoder package
// Shared types and constants: transaction payloads, region codes, monitor
// request codes and configuration register indexes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bcmio_pkg;

    localparam int ADDR_BITS = 13;
    localparam int PAGE_BITS = 5;
    localparam int CFG_IDX_BITS = 3;
    localparam int CFG_DATA_BITS = 13;

    localparam logic [7:0] NO_DATA_BYTE = 8'hFF;

    // Decoded regions.
    localparam logic [2:0] REGION_RAM         = 3'd0;
    localparam logic [2:0] REGION_UART_STATUS = 3'd1;
    localparam logic [2:0] REGION_UART_DATA   = 3'd2;
    localparam logic [2:0] REGION_DEBUG       = 3'd3;
    localparam logic [2:0] REGION_BAD_IO      = 3'd4;
    localparam logic [2:0] REGION_UNMAPPED    = 3'd5;

    // Monitor request codes.
    localparam logic [1:0] MON_NONE       = 2'd0;
    localparam logic [1:0] MON_ACCESS     = 2'd1;
    localparam logic [1:0] MON_DEBUG_READ = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_BITS-1:0] CFG_RAM_BASE         = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_UART_STATUS_ADDR = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_UART_DATA_ADDR   = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_DEBUG_PAGE       = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_STEP_MODE        = 3'd4;

    typedef struct packed {
        logic                 op;
        logic [ADDR_BITS-1:0] address;
        logic                 io_space;
        logic [7:0]           write_data;
        logic [1:0]           uart_flags;
        logic [7:0]           uart_rx_byte;
        logic [7:0]           debug_byte;
    } bus_item_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic [2:0] region;
        logic       tx_valid;
        logic [7:0] tx_byte;
        logic [1:0] monitor_request;
        logic       halt_request;
    } bus_result_t;

endpackage

[sv/bus_cycle_memory_io_decoder_unit.sv]
// ----------------------------------------------------------------------------
// Bus cycle memory and I/O decoder
// Decodes one processor bus cycle per transaction against the RAM window and
// the UART and debug-port I/O registers, and accesses the internal RAM.
// ----------------------------------------------------------------------------
// Each accepted transaction is registered in the decode stage and then in the result stage.
// Throughput: one transaction per cycle; an output stall holds both stages and
// drops in_ready once the decode stage is also full.
// Reset: configuration returns to its defaults, the last driven byte clears
// to zero and the pipeline empties. RAM contents are not cleared.
`timescale 1ns / 1ps

module bus_cycle_memory_io_decoder_unit
    import bcmio_pkg::*;
#(
    parameter int RAM_DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  bus_item_t                in_data,
    output logic                     out_valid,
    input  logic                     out_ready,
    output bus_result_t              out_data,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [CFG_DATA_BITS-1:0] cfg_data
);

    localparam int IDX_W = (RAM_DEPTH > 1) ? $clog2(RAM_DEPTH) : 1;
    localparam logic [ADDR_BITS:0] WINDOW_SPAN = (ADDR_BITS + 1)'(RAM_DEPTH);

    // Read data source of a transaction held in the decode stage.
    localparam logic [1:0] RSEL_DIRECT = 2'd0;
    localparam logic [1:0] RSEL_RAM    = 2'd1;
    localparam logic [1:0] RSEL_LAST   = 2'd2;

    // Configuration registers.
    logic [ADDR_BITS-1:0] ram_base_reg;
    logic [ADDR_BITS-1:0] uart_status_addr_reg;
    logic [ADDR_BITS-1:0] uart_data_addr_reg;
    logic [PAGE_BITS-1:0] debug_page_reg;
    logic                 step_mode_reg;

    // Pipeline state.
    logic        s1_valid_reg;
    bus_result_t s1_res_reg;
    bus_result_t s1_res_next;
    logic [1:0]  s1_rsel_reg;
    logic [1:0]  s1_rsel_next;
    logic        s1_is_read_reg;
    logic        out_valid_reg;
    bus_result_t out_res_reg;
    bus_result_t out_res_next;
    logic [7:0]  last_byte_reg;
    logic [7:0]  ram_rdata_reg;

    logic [7:0]  ram_mem [RAM_DEPTH];

    logic                 accept;
    logic                 s1_advance;
    logic                 out_free;
    logic [ADDR_BITS:0]   offset;
    logic                 in_ram;
    logic [PAGE_BITS-1:0] page;
    logic [IDX_W-1:0]     ram_idx;
    logic                 ram_we;
    logic                 ram_re;
    logic [1:0]           mon;

    assign cfg_ready  = 1'b1;
    assign out_free   = !out_valid_reg || out_ready;
    assign s1_advance = s1_valid_reg && out_free;
    assign in_ready   = !s1_valid_reg || out_free;
    assign accept     = in_valid && in_ready;
    assign out_valid  = out_valid_reg;
    assign out_data   = out_res_reg;

    // RAM window hit, computed one bit wider so the window never wraps.
    assign offset  = {1'b0, in_data.address} - {1'b0, ram_base_reg};
    assign in_ram  = !offset[ADDR_BITS] && (offset < WINDOW_SPAN);
    assign ram_idx = offset[IDX_W-1:0];
    assign page    = in_data.address[ADDR_BITS-1:ADDR_BITS-PAGE_BITS];
    assign ram_we  = accept && in_ram && in_data.op;
    assign ram_re  = accept && in_ram && !in_data.op;

    // Decode stage.
    always_comb
    begin
        s1_res_next  = '0;
        s1_rsel_next = RSEL_DIRECT;
        mon          = MON_NONE;
        s1_res_next.region = REGION_UNMAPPED;
        if (!in_data.op)
        begin
            priority if (in_ram)
            begin
                s1_res_next.region = REGION_RAM;
                s1_rsel_next       = RSEL_RAM;
            end
            else if (!in_data.io_space)
            begin
                s1_res_next.read_data = NO_DATA_BYTE;
            end
            else if (in_data.address == uart_status_addr_reg)
            begin
                s1_res_next.region    = REGION_UART_STATUS;
                s1_res_next.read_data = {6'd0, in_data.uart_flags};
            end
            else if (in_data.address == uart_data_addr_reg)
            begin
                s1_res_next.region    = REGION_UART_DATA;
                s1_res_next.read_data = in_data.uart_rx_byte;
            end
            else if (page == debug_page_reg)
            begin
                s1_res_next.region    = REGION_DEBUG;
                s1_res_next.read_data = in_data.debug_byte;
                mon                   = MON_DEBUG_READ;
            end
            else
            begin
                s1_res_next.region = REGION_BAD_IO;
                s1_rsel_next       = RSEL_LAST;
                mon                = MON_ACCESS;
            end
        end
        else
        begin
            // Writes are not matched against the status address; only the data address is compared.
            priority if (in_ram)
            begin
                s1_res_next.region = REGION_RAM;
            end
            else if (!in_data.io_space)
            begin
                s1_res_next.region = REGION_UNMAPPED;
            end
            else if (in_data.address == uart_data_addr_reg)
            begin
                s1_res_next.region   = REGION_UART_DATA;
                s1_res_next.tx_valid = 1'b1;
                s1_res_next.tx_byte  = in_data.write_data;
            end
            else if (page == debug_page_reg)
            begin
                s1_res_next.region = REGION_DEBUG;
                mon                = MON_ACCESS;
            end
            else
            begin
                s1_res_next.region = REGION_BAD_IO;
                mon                = MON_ACCESS;
            end
        end
        s1_res_next.monitor_request = mon;
        s1_res_next.halt_request    = step_mode_reg || (mon != MON_NONE);
    end

    // Result stage: pick the read byte now that RAM data and the previous
    // read's byte are both settled.
    always_comb
    begin
        out_res_next = s1_res_reg;
        unique case (s1_rsel_reg)
            RSEL_RAM:  out_res_next.read_data = ram_rdata_reg;
            RSEL_LAST: out_res_next.read_data = last_byte_reg;
            default:   out_res_next.read_data = s1_res_reg.read_data;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ram_base_reg         <= '0;
            uart_status_addr_reg <= '0;
            uart_data_addr_reg   <= ADDR_BITS'(1);
            debug_page_reg       <= '1;
            step_mode_reg        <= 1'b0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_RAM_BASE:         ram_base_reg         <= cfg_data[ADDR_BITS-1:0];
                CFG_UART_STATUS_ADDR: uart_status_addr_reg <= cfg_data[ADDR_BITS-1:0];
                CFG_UART_DATA_ADDR:   uart_data_addr_reg   <= cfg_data[ADDR_BITS-1:0];
                CFG_DEBUG_PAGE:       debug_page_reg       <= cfg_data[PAGE_BITS-1:0];
                CFG_STEP_MODE:        step_mode_reg        <= cfg_data[0];
                default:              ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            last_byte_reg <= '0;
        end
        else
        begin
            if (in_ready)
            begin
                s1_valid_reg <= in_valid;
            end
            if (out_free)
            begin
                out_valid_reg <= s1_valid_reg;
            end
            if (s1_advance && s1_is_read_reg)
            begin
                last_byte_reg <= out_res_next.read_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_res_reg     <= s1_res_next;
            s1_rsel_reg    <= s1_rsel_next;
            s1_is_read_reg <= !in_data.op;
        end
        if (s1_advance)
        begin
            out_res_reg <= out_res_next;
        end
    end

    // Single-port RAM with registered read data.
    always_ff @(posedge clk)
    begin
        if (ram_we)
        begin
            ram_mem[ram_idx] <= in_data.write_data;
        end
        if (ram_re)
        begin
            ram_rdata_reg <= ram_mem[ram_idx];
        end
    end

    a_tx_only_uart_data: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_res_reg.tx_valid |->
            out_res_reg.region == REGION_UART_DATA
            && out_res_reg.monitor_request == MON_NONE)
        else $error("transmit byte outside UART data region");

    a_idle_tx_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_res_reg.tx_valid |-> out_res_reg.tx_byte == 8'd0)
        else $error("transmit byte nonzero without transmit");

    a_halt_on_monitor: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_res_reg.monitor_request != MON_NONE
            |-> out_res_reg.halt_request)
        else $error("monitor request without halt request");

    a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && out_valid_reg && !out_ready |-> !in_ready)
        else $error("input taken while decode stage is stalled");

    a_stall_keeps_stage: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !out_free |=> s1_valid_reg && $stable(s1_res_reg))
        else $error("decode stage lost a transaction during stall");

endmodule

[verif/testbench.sv]
// ----------------------------------------------------------------------------
// Bus cycle decoder testbench
// Drives processor bus cycles through the decoder under several register
// settings and random flow control. A scoreboard keeps its own image of the
// RAM, the last driven byte and the registers, and checks every result in
// order against what it predicts.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

import bcmio_pkg::*;

localparam logic OP_READ   = 1'b0;
localparam logic OP_WRITE  = 1'b1;
localparam int   RAM_WORDS = 4096;

class bus_decode_scoreboard;

    logic [7:0]           ram_image [RAM_WORDS];
    bit                   written [RAM_WORDS];
    int                   written_list [$];
    logic [7:0]           last_byte;
    logic [ADDR_BITS-1:0] ram_base;
    logic [ADDR_BITS-1:0] status_addr;
    logic [ADDR_BITS-1:0] data_addr;
    logic [PAGE_BITS-1:0] debug_page;
    logic                 step_mode;
    bus_result_t          expected_results [$];
    int                   errors;
    int                   checked;
    int                   region_count [6];
    int                   tx_count;
    int                   halt_count;

    function new();
        last_byte = 8'h00;
        ram_base = '0;
        status_addr = '0;
        data_addr = 13'd1;
        debug_page = 5'd31;
        step_mode = 1'b0;
        errors = 0;
        checked = 0;
        tx_count = 0;
        halt_count = 0;
        foreach (region_count[i]) region_count[i] = 0;
    endfunction

    function void set_register(logic [CFG_IDX_BITS-1:0] idx,
                               logic [CFG_DATA_BITS-1:0] value);
        case (idx)
            CFG_RAM_BASE:         ram_base = value;
            CFG_UART_STATUS_ADDR: status_addr = value;
            CFG_UART_DATA_ADDR:   data_addr = value;
            CFG_DEBUG_PAGE:       debug_page = value[PAGE_BITS-1:0];
            CFG_STEP_MODE:        step_mode = value[0];
            default:              ;
        endcase
    endfunction

    // Offset into the RAM window, or -1 when the address misses it.
    function int ram_offset(logic [ADDR_BITS-1:0] addr);
        int delta;
        delta = int'(addr) - int'(ram_base);
        if (delta >= 0 && delta < RAM_WORDS)
            return delta;
        return -1;
    endfunction

    function bus_result_t decode_cycle(bus_item_t item);
        bus_result_t r;
        int          offset;
        logic        page_hit;
        r = '0;
        r.region = REGION_UNMAPPED;
        offset = ram_offset(item.address);
        page_hit = (item.address[ADDR_BITS-1 -: PAGE_BITS] == debug_page);
        if (item.op == OP_READ)
        begin
            if (offset >= 0)
            begin
                r.region = REGION_RAM;
                r.read_data = ram_image[offset];
            end
            else if (item.io_space)
            begin
                if (item.address == status_addr)
                begin
                    r.region = REGION_UART_STATUS;
                    r.read_data = {6'b0, item.uart_flags};
                end
                else if (item.address == data_addr)
                begin
                    r.region = REGION_UART_DATA;
                    r.read_data = item.uart_rx_byte;
                end
                else if (page_hit)
                begin
                    r.region = REGION_DEBUG;
                    r.read_data = item.debug_byte;
                    r.monitor_request = MON_DEBUG_READ;
                end
                else
                begin
                    r.region = REGION_BAD_IO;
                    r.read_data = last_byte;
                    r.monitor_request = MON_ACCESS;
                end
            end
            else
            begin
                r.read_data = NO_DATA_BYTE;
            end
            last_byte = r.read_data;
        end
        else
        begin
            if (offset >= 0)
            begin
                r.region = REGION_RAM;
                ram_image[offset] = item.write_data;
                if (!written[offset])
                begin
                    written[offset] = 1'b1;
                    written_list.push_back(offset);
                end
            end
            else if (item.io_space)
            begin
                // The status address is read-only, so a write to it falls through.
                if (item.address == data_addr)
                begin
                    r.region = REGION_UART_DATA;
                    r.tx_valid = 1'b1;
                    r.tx_byte = item.write_data;
                end
                else
                begin
                    r.region = page_hit ? REGION_DEBUG : REGION_BAD_IO;
                    r.monitor_request = MON_ACCESS;
                end
            end
        end
        r.halt_request = step_mode || (r.monitor_request != MON_NONE);
        region_count[r.region]++;
        tx_count += r.tx_valid;
        halt_count += r.halt_request;
        return r;
    endfunction

    function void note_cycle(bus_item_t item);
        expected_results.push_back(decode_cycle(item));
    endfunction

    function int outstanding();
        return expected_results.size();
    endfunction

    function void compare_field(string field, logic [7:0] want, logic [7:0] got);
        if (got !== want)
        begin
            errors++;
            $display("%0t ns: %s mismatch, expected %0h, got %0h",
                     $time, field, want, got);
        end
    endfunction

    function void check_result(bus_result_t got);
        bus_result_t want;
        if (expected_results.size() == 0)
        begin
            errors++;
            $display("%0t ns: result %h arrived with nothing expected", $time, got);
            return;
        end
        want = expected_results.pop_front();
        checked++;
        compare_field("read_data", want.read_data, got.read_data);
        compare_field("region", 8'(want.region), 8'(got.region));
        compare_field("tx_valid", 8'(want.tx_valid), 8'(got.tx_valid));
        compare_field("tx_byte", want.tx_byte, got.tx_byte);
        compare_field("monitor_request", 8'(want.monitor_request), 8'(got.monitor_request));
        compare_field("halt_request", 8'(want.halt_request), 8'(got.halt_request));
    endfunction

endclass

module testbench;

    localparam int CYCLE_LIMIT    = 200000;
    localparam int PHASES         = 8;
    localparam int PHASE_ITEMS    = 229;
    localparam int RX_HOLD_CYCLES = 400;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     in_valid = 1'b0;
    logic                     in_ready;
    bus_item_t                in_data = '0;
    logic                     out_valid;
    logic                     out_ready = 1'b0;
    bus_result_t              out_data;
    logic                     cfg_valid = 1'b0;
    logic                     cfg_ready;
    logic [CFG_IDX_BITS-1:0]  cfg_index = '0;
    logic [CFG_DATA_BITS-1:0] cfg_data = '0;

    logic calm = 1'b0;
    logic hold_req = 1'b0;
    int   cycles = 0;
    int   sent = 0;
    int   settings = 1;

    bus_decode_scoreboard board = new();

    bus_cycle_memory_io_decoder_unit #(.RAM_DEPTH(RAM_WORDS)) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    // A read of a RAM entry that was never written is turned into a write.
    function automatic bus_item_t keep_ram_defined(bus_item_t item);
        int offset;
        offset = board.ram_offset(item.address);
        if (item.op == OP_READ && offset >= 0 && !board.written[offset])
            item.op = OP_WRITE;
        return item;
    endfunction

    function automatic bus_item_t cycle_of(logic op, logic [ADDR_BITS-1:0] addr, logic io,
                                           logic [7:0] wdata, logic [1:0] flags);
        bus_item_t item;
        item.op = op;
        item.address = addr;
        item.io_space = io;
        item.write_data = wdata;
        item.uart_flags = flags;
        item.uart_rx_byte = 8'($urandom_range(0, 255));
        item.debug_byte = 8'($urandom_range(0, 255));
        return item;
    endfunction

    function automatic bus_item_t random_cycle();
        bus_item_t item;
        int        pick;
        int        span;
        int        offset;
        item = cycle_of(1'($urandom_range(0, 1)), 13'($urandom_range(0, 8191)),
                        1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                        2'($urandom_range(0, 3)));
        pick = $urandom_range(0, 99);
        if (pick < 35)
        begin
            span = 8192 - int'(board.ram_base);
            if (span > RAM_WORDS)
                span = RAM_WORDS;
            offset = $urandom_range(0, span - 1);
            if (item.op == OP_READ && board.written_list.size() > 0)
            begin
                for (int tries = 0; tries < 8; tries++)
                begin
                    offset = board.written_list[
                        $urandom_range(0, board.written_list.size() - 1)];
                    if (offset < span)
                        break;
                end
            end
            item.address = board.ram_base + 13'(offset);
        end
        else if (pick < 50)
        begin
            item.address = board.status_addr;
            item.io_space = 1'b1;
        end
        else if (pick < 65)
        begin
            item.address = board.data_addr;
            item.io_space = 1'b1;
        end
        else if (pick < 78)
        begin
            item.address = {board.debug_page, 8'($urandom_range(0, 255))};
            item.io_space = 1'b1;
        end
        return item;
    endfunction

    task automatic send_cycle(input bus_item_t item);
        bus_item_t safe;
        safe = keep_ram_defined(item);
        in_valid <= 1'b1;
        in_data <= safe;
        do @(posedge clk); while (!in_ready);
        board.note_cycle(safe);
        sent++;
    endtask

    task automatic sender_gap(input int n);
        in_valid <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (board.outstanding() != 0) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do @(posedge clk); while (!cfg_ready);
        board.set_register(idx, value);
    endtask

    task automatic configure(input logic [CFG_DATA_BITS-1:0] base, status, data,
                             page_word, step_word);
        write_reg(CFG_RAM_BASE, base);
        write_reg(CFG_UART_STATUS_ADDR, status);
        write_reg(CFG_UART_DATA_ADDR, data);
        write_reg(CFG_DEBUG_PAGE, page_word);
        write_reg(CFG_STEP_MODE, step_word);
        cfg_valid <= 1'b0;
        settings++;
    endtask

    // Result side: checks each accepted transaction and chooses the next ready.
    initial
    begin
        int   hold_left;
        logic hold_seen;
        hold_left = 0;
        hold_seen = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && out_ready)
                board.check_result(out_data);
            if (hold_req != hold_seen)
            begin
                hold_seen = hold_req;
                hold_left = RX_HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= calm || ($urandom_range(0, 99) >= 26);
            end
        end
    end

    initial
    begin
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("timeout after %0d cycles with %0d results outstanding",
                 cycles, board.outstanding());
        $display("[bus_cycle_memory_io_decoder_unit] ERROR");
        $finish;
    end

    initial
    begin
        int burst_left;
        burst_left = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: RAM at 0..4095, UART registers hidden under the RAM.
        send_cycle(cycle_of(OP_WRITE, 13'h0000, 1'b0, 8'h00, 2'b00));
        send_cycle(cycle_of(OP_WRITE, 13'h0FFF, 1'b1, 8'hFF, 2'b11));
        send_cycle(cycle_of(OP_READ,  13'h0000, 1'b0, 8'hFF, 2'b00));
        send_cycle(cycle_of(OP_READ,  13'h0FFF, 1'b1, 8'h00, 2'b11));
        send_cycle(cycle_of(OP_WRITE, 13'h1000, 1'b0, 8'hA5, 2'b01));
        send_cycle(cycle_of(OP_READ,  13'h1FFF, 1'b0, 8'h00, 2'b10));
        send_cycle(cycle_of(OP_READ,  13'h1000, 1'b1, 8'h00, 2'b00));
        send_cycle(cycle_of(OP_READ,  13'h1FFF, 1'b1, 8'h00, 2'b11));
        send_cycle(cycle_of(OP_WRITE, 13'h1F80, 1'b1, 8'h11, 2'b00));
        send_cycle(cycle_of(OP_WRITE, 13'h1001, 1'b1, 8'h22, 2'b00));
        drain();

        // UART registers outside the window; the status address sits in debug page 0.
        configure(13'h1000, 13'h0010, 13'h0011, 13'h1FE0, 13'h1FFE);
        send_cycle(cycle_of(OP_READ,  13'h0010, 1'b1, 8'h00, 2'b11));
        send_cycle(cycle_of(OP_READ,  13'h0010, 1'b1, 8'h00, 2'b00));
        send_cycle(cycle_of(OP_READ,  13'h0011, 1'b1, 8'h00, 2'b01));
        send_cycle(cycle_of(OP_WRITE, 13'h0011, 1'b1, 8'h5A, 2'b10));
        send_cycle(cycle_of(OP_WRITE, 13'h0010, 1'b1, 8'hC3, 2'b00));
        send_cycle(cycle_of(OP_READ,  13'h0010, 1'b0, 8'h00, 2'b00));
        send_cycle(cycle_of(OP_WRITE, 13'h1000, 1'b0, 8'h3C, 2'b00));
        send_cycle(cycle_of(OP_READ,  13'h1000, 1'b0, 8'h00, 2'b00));
        drain();

        // Equal UART addresses, a one-byte RAM window and single-step mode.
        configure(13'h1FFF, 13'h0020, 13'h0020, 13'h0005, 13'h0001);
        send_cycle(cycle_of(OP_READ,  13'h0020, 1'b1, 8'h00, 2'b10));
        send_cycle(cycle_of(OP_WRITE, 13'h0020, 1'b1, 8'h81, 2'b00));
        send_cycle(cycle_of(OP_WRITE, 13'h1FFF, 1'b0, 8'h7E, 2'b00));
        send_cycle(cycle_of(OP_READ,  13'h1FFF, 1'b1, 8'h00, 2'b00));
        send_cycle(cycle_of(OP_READ,  13'h1FFE, 1'b0, 8'h00, 2'b00));
        send_cycle(cycle_of(OP_WRITE, 13'h0540, 1'b1, 8'h99, 2'b00));

        for (int phase = 0; phase < PHASES; phase++)
        begin
            drain();
            case (phase)
                0: configure(13'h0800, 13'h1800, 13'h1801, 13'h0019, 13'h0000);
                1: configure(13'h1FFF, 13'h0000, 13'h0000, 13'h0000, 13'h0001);
                2: configure(13'h0000, 13'h1FFF, 13'h1FFE, 13'h1FFF, 13'h1FFE);
                default: configure(13'($urandom_range(0, 8191)), 13'($urandom_range(0, 8191)),
                                   13'($urandom_range(0, 8191)), 13'($urandom_range(0, 8191)),
                                   13'($urandom_range(0, 8191)));
            endcase
            calm <= (phase == 3);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                // The result side stops for a long while; the input must back up.
                if (phase == 4 && n == 40)
                begin
                    hold_req <= ~hold_req;
                    burst_left = 80;
                end
                if (burst_left > 0)
                    burst_left--;
                else if (!calm && $urandom_range(0, 99) < 26)
                    sender_gap($urandom_range(1, 4));
                send_cycle(random_cycle());
            end
        end

        drain();
        repeat (8) @(posedge clk);
        $display("Covered %0d bus cycles under %0d register settings in %0d clock cycles.",
                 sent, settings, cycles);
        $display({"Regions RAM/status/data/debug/bad/unmapped: %0d/%0d/%0d/%0d/%0d/%0d, ",
                  "%0d transmits, %0d halts, %0d mismatches."},
                 board.region_count[0], board.region_count[1], board.region_count[2],
                 board.region_count[3], board.region_count[4], board.region_count[5],
                 board.tx_count, board.halt_count, board.errors);
        if (board.errors == 0 && board.outstanding() == 0 && board.checked == sent)
            $display("[bus_cycle_memory_io_decoder_unit] OK");
        else
            $display("[bus_cycle_memory_io_decoder_unit] ERROR");
        $finish;
    end

endmodule

[files.f]
sv/bcmio_pkg.sv
sv/bus_cycle_memory_io_decoder_unit.sv
verif/testbench.sv
